// ===== sv/dma_coherency_line_checker_assert.svh =====
// Assertion helpers for the coherency line checker.
`ifndef DMA_COHERENCY_LINE_CHECKER_ASSERT_SVH
`define DMA_COHERENCY_LINE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define DCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define DCL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define DCL_ASSERT(lbl, prop)
`define DCL_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== sv/dcl_pkg.sv =====
package dcl_pkg;

  localparam int LINE_COUNT       = 65536;
  localparam int LINE_BYTES       = 32;
  localparam int LINE_SHIFT       = $clog2(LINE_BYTES);
  localparam int IDX_W            = $clog2(LINE_COUNT);
  localparam int BURST_SLOTS      = 4;
  localparam int SLOT_W           = (BURST_SLOTS > 1) ? $clog2(BURST_SLOTS) : 1;
  localparam int MAX_ACCESS_LINES = 2048;

  typedef enum logic [2:0] {
    CMD_CLEAN  = 3'd0,
    CMD_INVAL  = 3'd1,
    CMD_FLUSH  = 3'd2,
    CMD_DMA_RD = 3'd3,
    CMD_DMA_WR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNKNOWN    = 2'd0,
    ST_CLEAN      = 2'd1,
    ST_INVALID    = 2'd2,
    ST_DEVWRITTEN = 2'd3
  } line_state_e;

  typedef enum logic [2:0] {
    VIOL_NONE          = 3'd0,
    VIOL_WR_AFTER_CLN  = 3'd1,
    VIOL_WR_REUSED     = 3'd2,
    VIOL_WR_UNKNOWN    = 3'd3,
    VIOL_RD_MODIFIED   = 3'd4,
    VIOL_RD_UNCLEANED  = 3'd5
  } viol_e;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_RAM_BASE = 2'd1,
    CFG_RAM_SIZE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        all_lines;
    logic [31:0] address;
    logic [16:0] length;
    logic [10:0] line_step;
    logic [31:0] content_hash;
  } in_t;

  typedef struct packed {
    logic [31:0] line_address;
    logic        ignored;
    logic [2:0]  violation;
    logic [31:0] violation_count;
    logic [31:0] cache_op_count;
    logic [31:0] dma_count;
  } out_t;

  typedef struct packed {
    line_state_e state;
    logic        enrolled;
    logic [31:0] hash;
  } tbl_entry_t;

  typedef struct packed {
    logic             st_we;
    logic             enr_we;
    logic [IDX_W-1:0] idx;
    line_state_e      state;
    logic [31:0]      hash;
    logic             enrolled;
  } tbl_wr_t;

  typedef struct packed {
    logic        start;
    logic        wr_req;
    logic [32:0] start_addr;
    logic [32:0] end_addr;
  } burst_req_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

// ===== sv/dma_coherency_line_checker.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------
// input    | in_valid_i / in_stall_o    | in_data_i  (in_t)
// output   | out_valid_o / out_stall_i  | out_data_o (out_t)
// config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A line item passes through accept, line table read, then update and result.
// A whole-cache item also walks the tracked lines (at most LINE_COUNT):
// the walk writes one table row per cycle on the single port.
// After reset a clearing pass writes all LINE_COUNT rows, one per cycle;
// input is stalled meanwhile, configuration writes are taken at any time.
// Input is taken whenever the controller is idle; while a result waits,
// the next item holds in its last cycle until the result is transferred.
`include "dma_coherency_line_checker_assert.svh"

module dma_coherency_line_checker
  import dcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_WALK
  } state_e;

  state_e           state_q;
  in_t              item_q;
  logic             enable_q;
  logic [31:0]      base_q;
  logic [32:0]      size_q;
  logic [IDX_W:0]   walk_q;
  logic [31:0]      viol_cnt_q, cache_cnt_q, dma_cnt_q;
  logic             act_q;
  logic [31:0]      la_q;
  logic [IDX_W-1:0] idx_q;
  out_t             out_q;
  logic             out_valid_q;
  logic             out_free, out_load;

  tbl_entry_t       rd;
  tbl_wr_t          tbl_wr;
  burst_req_t       breq;
  logic             cont;

  // address decode for the item under work
  logic             is_cache, is_dma, is_wr;
  logic [33:0]      base_x, lim_x, addr_x, la_x, diff_x;
  logic [31:0]      aligned;
  logic [32:0]      end_x;
  logic             addr_ok, la_in, slot_ok, dma_ok, line_ok, cache_ok;
  logic [IDX_W-1:0] idx;
  logic             walk_run;

  assign is_cache = (item_q.cmd == CMD_CLEAN) || (item_q.cmd == CMD_INVAL) ||
                    (item_q.cmd == CMD_FLUSH);
  assign is_dma   = (item_q.cmd == CMD_DMA_RD) || (item_q.cmd == CMD_DMA_WR);
  assign is_wr    = (item_q.cmd == CMD_DMA_WR);
  assign base_x   = {2'b0, base_q};
  assign lim_x    = base_x + {1'b0, size_q};
  assign addr_x   = {2'b0, item_q.address};
  assign aligned  = {item_q.address[31:LINE_SHIFT], LINE_SHIFT'(0)};
  assign la_x     = is_dma ? {2'b0, aligned} + (34'(item_q.line_step) << LINE_SHIFT)
                           : {2'b0, aligned};
  assign diff_x   = la_x - base_x;
  assign end_x    = {1'b0, item_q.address} + 33'(item_q.length);
  assign addr_ok  = (size_q != '0) && (addr_x >= base_x) && (addr_x < lim_x);
  assign la_in    = (size_q != '0) && (la_x >= base_x) && (la_x < lim_x);
  assign slot_ok  = la_in && ((diff_x >> LINE_SHIFT) < 34'(LINE_COUNT));
  assign idx      = diff_x[LINE_SHIFT +: IDX_W];
  assign dma_ok   = enable_q && is_dma && addr_ok;
  assign line_ok  = dma_ok && (32'(item_q.line_step) < 32'(MAX_ACCESS_LINES)) &&
                    (la_x < {1'b0, end_x}) && slot_ok;
  assign cache_ok = enable_q && is_cache && !item_q.all_lines && addr_ok && slot_ok;
  assign walk_run = (walk_q < (IDX_W+1)'(LINE_COUNT)) &&
                    (34'({walk_q, LINE_SHIFT'(0)}) < {1'b0, size_q});

  // a finished item may leave once the output register is free
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free &&
                    ((state_q == S_EXEC) || ((state_q == S_WALK) && !walk_run));

  always_comb begin
    breq.start      = (state_q == S_CALC) && dma_ok && (item_q.line_step == '0);
    breq.wr_req     = is_wr;
    breq.start_addr = {1'b0, item_q.address};
    breq.end_addr   = end_x;
  end

  dcl_burst u_burst (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (breq),
    .cont_o (cont)
  );

  // update of the line under judgment
  logic [2:0]  viol;
  tbl_wr_t     exec_wr;
  logic [31:0] viol_cnt_next;

  always_comb begin
    viol             = VIOL_NONE;
    exec_wr          = '0;
    exec_wr.idx      = idx_q;
    exec_wr.state    = rd.state;
    exec_wr.hash     = rd.hash;
    exec_wr.enrolled = 1'b1;
    if (act_q) begin
      if (is_cache) begin
        exec_wr.st_we  = 1'b1;
        exec_wr.enr_we = 1'b1;
        exec_wr.state  = (item_q.cmd == CMD_CLEAN) ? ST_CLEAN : ST_INVALID;
        exec_wr.hash   = (item_q.cmd == CMD_CLEAN) ? item_q.content_hash : '0;
      end else if (is_wr && cont) begin
        if (rd.enrolled && rd.state == ST_INVALID) begin
          exec_wr.st_we = 1'b1;
          exec_wr.state = ST_DEVWRITTEN;
        end
      end else if (rd.enrolled) begin
        if (is_wr) begin
          unique case (rd.state)
            ST_CLEAN:      viol = VIOL_WR_AFTER_CLN;
            ST_DEVWRITTEN: viol = VIOL_WR_REUSED;
            ST_UNKNOWN:    viol = VIOL_WR_UNKNOWN;
            default:       viol = VIOL_NONE;
          endcase
          exec_wr.st_we = 1'b1;
          exec_wr.state = ST_DEVWRITTEN;
        end else if (rd.state == ST_CLEAN && rd.hash != '0 &&
                     rd.hash != item_q.content_hash) begin
          viol = VIOL_RD_MODIFIED;
        end else if (rd.state == ST_UNKNOWN) begin
          viol = VIOL_RD_UNCLEANED;
        end
      end
    end
    viol_cnt_next = (viol != VIOL_NONE) ? sat_inc(viol_cnt_q) : viol_cnt_q;
  end

  always_comb begin
    tbl_wr = '0;
    unique case (state_q)
      S_CLEAR: begin
        tbl_wr.st_we  = 1'b1;
        tbl_wr.enr_we = 1'b1;
        tbl_wr.idx    = walk_q[IDX_W-1:0];
        tbl_wr.state  = ST_UNKNOWN;
      end
      S_WALK: begin
        tbl_wr.st_we = walk_run;
        tbl_wr.idx   = walk_q[IDX_W-1:0];
        tbl_wr.state = (item_q.cmd == CMD_CLEAN) ? ST_CLEAN : ST_INVALID;
      end
      S_EXEC: begin
        if (out_free) begin
          tbl_wr = exec_wr;
        end
      end
      default: tbl_wr = '0;
    endcase
  end

  dcl_table u_table (
    .clk_i    (clk_i),
    .rd_en_i  (state_q == S_CALC),
    .rd_idx_i (idx),
    .rd_o     (rd),
    .wr_i     (tbl_wr)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      base_q   <= '0;
      size_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:   enable_q <= cfg_data_i[0];
        CFG_RAM_BASE: base_q   <= cfg_data_i[31:0];
        CFG_RAM_SIZE: size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      walk_q      <= '0;
      viol_cnt_q  <= '0;
      cache_cnt_q <= '0;
      dma_cnt_q   <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (walk_q[IDX_W-1:0] == '1) begin
            walk_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (is_cache && enable_q) begin
            cache_cnt_q <= sat_inc(cache_cnt_q);
          end
          if (breq.start) begin
            dma_cnt_q <= sat_inc(dma_cnt_q);
          end
          act_q   <= line_ok || cache_ok;
          la_q    <= la_x[31:0];
          idx_q   <= idx;
          walk_q  <= '0;
          state_q <= (is_cache && enable_q && item_q.all_lines) ? S_WALK : S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            viol_cnt_q               <= viol_cnt_next;
            out_q.line_address       <= la_q;
            out_q.ignored            <= !act_q;
            out_q.violation          <= viol;
            out_q.violation_count    <= viol_cnt_next;
            out_q.cache_op_count     <= cache_cnt_q;
            out_q.dma_count          <= dma_cnt_q;
            state_q                  <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_run) begin
            walk_q <= walk_q + 1'b1;
          end else if (out_free) begin
            out_q.line_address    <= base_q;
            out_q.ignored         <= (size_q == '0);
            out_q.violation       <= VIOL_NONE;
            out_q.violation_count <= viol_cnt_q;
            out_q.cache_op_count  <= cache_cnt_q;
            out_q.dma_count       <= dma_cnt_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DCL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `DCL_ASSERT(a_no_write_idle, (state_q == S_IDLE) |-> !(tbl_wr.st_we || tbl_wr.enr_we))
  `DCL_ASSERT(a_ignored_no_viol, out_valid_o |-> !(out_data_o.ignored && out_data_o.violation != VIOL_NONE))
  `DCL_ASSERT_NEXT(a_accept_to_calc, in_valid_i && !in_stall_o, state_q == S_CALC)

endmodule

// ===== sv/dcl_table.sv =====
module dcl_table
  import dcl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output tbl_entry_t       rd_o,
  input  tbl_wr_t          wr_i
);

  // state and hash in one memory, enrolled mark in another so that a
  // whole-cache walk can write state without reading first
  logic [33:0] st_mem [LINE_COUNT];
  logic        enr_mem [LINE_COUNT];
  logic [33:0] st_rd_q;
  logic        enr_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.st_we) begin
      st_mem[wr_i.idx] <= {wr_i.state, wr_i.hash};
    end
    if (rd_en_i) begin
      st_rd_q <= st_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.enr_we) begin
      enr_mem[wr_i.idx] <= wr_i.enrolled;
    end
    if (rd_en_i) begin
      enr_rd_q <= enr_mem[rd_idx_i];
    end
  end

  always_comb begin
    rd_o.state    = line_state_e'(st_rd_q[33:32]);
    rd_o.hash     = st_rd_q[31:0];
    rd_o.enrolled = enr_rd_q;
  end

endmodule

// ===== sv/dcl_burst.sv =====
module dcl_burst
  import dcl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  burst_req_t req_i,
  output logic       cont_o
);

  logic [32:0]       ends_q [BURST_SLOTS];
  logic [32:0]       ends_d [BURST_SLOTS];
  logic [SLOT_W-1:0] next_q, next_d;
  logic              cont_q, cont_d;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = BURST_SLOTS - 1; i >= 0; i--) begin
      if (ends_q[i] == req_i.start_addr) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ends_d = ends_q;
    next_d = next_q;
    cont_d = cont_q;
    if (req_i.start) begin
      cont_d = 1'b0;
      if (req_i.wr_req) begin
        if (hit) begin
          cont_d          = 1'b1;
          ends_d[hit_idx] = req_i.end_addr;
        end else begin
          ends_d[next_q] = req_i.end_addr;
          next_d = (next_q == SLOT_W'(BURST_SLOTS - 1)) ? '0 : next_q + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BURST_SLOTS; i++) begin
        ends_q[i] <= '0;
      end
      next_q <= '0;
      cont_q <= 1'b0;
    end else begin
      ends_q <= ends_d;
      next_q <= next_d;
      cont_q <= cont_d;
    end
  end

  assign cont_o = cont_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dcl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [32:0] cfg_data_i = '0;

  dma_coherency_line_checker u_dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    reg_idx;
    logic [32:0] reg_val;
    in_t         item;
    bit          typed;
    out_t        want;
  } row_t;

  // shadow of the line table and checker state
  line_state_e line_st   [LINE_COUNT];
  bit          line_enr  [LINE_COUNT];
  logic [31:0] line_sig  [LINE_COUNT];
  logic [63:0] burst_end [BURST_SLOTS];
  int unsigned burst_next;
  bit          continues;
  logic [31:0] viol_tot, cop_tot, dma_tot;
  bit          en;
  logic [63:0] base, size;

  out_t        pending_results[$];
  row_t        rows[$];
  int          errors;
  bit          quiet;
  bit          long_hold;
  logic [63:0] last_end;

  function automatic bit in_ram(logic [63:0] a);
    return size != 0 && a >= base && a < base + size;
  endfunction

  function automatic bit line_of(logic [63:0] a, output int unsigned idx);
    logic [63:0] i;
    idx = 0;
    if (!in_ram(a)) return 0;
    i = (a - base) / LINE_BYTES;
    if (i >= LINE_COUNT) return 0;
    idx = 32'(i);
    return 1;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic out_t judge_line(in_t it);
    logic [63:0] addr, len, step, aligned, la, e;
    int unsigned idx;
    line_state_e s;
    logic ign;
    viol_e v;
    bit wr;
    out_t r;
    addr = it.address;
    len = it.length;
    step = it.line_step;
    aligned = addr & ~64'(LINE_BYTES - 1);
    la = aligned;
    ign = 1'b1;
    v = VIOL_NONE;
    if (it.cmd <= CMD_FLUSH) begin
      if (en) begin
        cop_tot = bump(cop_tot);
        if (it.all_lines) begin
          la = base;
          for (int i = 0; i < LINE_COUNT; i++) begin
            if (64'(i) * LINE_BYTES >= size) break;
            line_st[i] = (it.cmd == CMD_CLEAN) ? ST_CLEAN : ST_INVALID;
            line_sig[i] = '0;
            ign = 1'b0;
          end
        end else if (in_ram(addr) && line_of(aligned, idx)) begin
          line_enr[idx] = 1'b1;
          line_st[idx] = (it.cmd == CMD_CLEAN) ? ST_CLEAN : ST_INVALID;
          line_sig[idx] = (it.cmd == CMD_CLEAN) ? it.content_hash : '0;
          ign = 1'b0;
        end
      end
    end else if (it.cmd <= CMD_DMA_WR) begin
      wr = (it.cmd == CMD_DMA_WR);
      la = aligned + step * LINE_BYTES;
      if (en && in_ram(addr)) begin
        e = addr + len;
        if (step == 0) begin
          dma_tot = bump(dma_tot);
          continues = 0;
          if (wr) begin
            for (int i = 0; i < BURST_SLOTS; i++) begin
              if (burst_end[i] == addr) begin
                continues = 1;
                burst_end[i] = e;
                break;
              end
            end
            if (!continues) begin
              burst_end[burst_next] = e;
              burst_next = (burst_next + 1) % BURST_SLOTS;
            end
          end
        end
        if (step < MAX_ACCESS_LINES && la < e && line_of(la, idx)) begin
          s = line_st[idx];
          ign = 1'b0;
          if (wr && continues) begin
            if (line_enr[idx] && s == ST_INVALID) line_st[idx] = ST_DEVWRITTEN;
          end else if (line_enr[idx]) begin
            if (wr) begin
              if (s == ST_CLEAN) v = VIOL_WR_AFTER_CLN;
              else if (s == ST_DEVWRITTEN) v = VIOL_WR_REUSED;
              else if (s == ST_UNKNOWN) v = VIOL_WR_UNKNOWN;
              line_st[idx] = ST_DEVWRITTEN;
            end else begin
              if (s == ST_CLEAN && line_sig[idx] != 0 && line_sig[idx] != it.content_hash)
                v = VIOL_RD_MODIFIED;
              else if (s == ST_UNKNOWN) v = VIOL_RD_UNCLEANED;
            end
            if (v != VIOL_NONE) viol_tot = bump(viol_tot);
          end
        end
      end
    end
    r.line_address = la[31:0];
    r.ignored = ign;
    r.violation = v;
    r.violation_count = viol_tot;
    r.cache_op_count = cop_tot;
    r.dma_count = dma_tot;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, line_address", out_data_o.line_address, '0);
      end else begin
        w = pending_results.pop_front();
        if (out_data_o.line_address !== w.line_address)
          report("line_address", out_data_o.line_address, w.line_address);
        if (out_data_o.ignored !== w.ignored)
          report("ignored", 32'(out_data_o.ignored), 32'(w.ignored));
        if (out_data_o.violation !== w.violation)
          report("violation", 32'(out_data_o.violation), 32'(w.violation));
        if (out_data_o.violation_count !== w.violation_count)
          report("violation_count", out_data_o.violation_count, w.violation_count);
        if (out_data_o.cache_op_count !== w.cache_op_count)
          report("cache_op_count", out_data_o.cache_op_count, w.cache_op_count);
        if (out_data_o.dma_count !== w.dma_count)
          report("dma_count", out_data_o.dma_count, w.dma_count);
      end
    end
  end

  // result side: stall a random number of cycles before each transfer
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 3);
      if (long_hold) begin
        n = 300;
        long_hold = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send(in_t it, bit typed = 0, out_t want = '0);
    int gap;
    out_t p;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    p = judge_line(it);
    pending_results.push_back(typed ? want : p);
  endtask

  // drain all results, then let the block settle before a register write
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e r, logic [32:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (r)
      CFG_ENABLE:   en = d[0];
      CFG_RAM_BASE: base = 64'(d[31:0]);
      CFG_RAM_SIZE: size = 64'(d);
      default: ;
    endcase
  endtask

  function automatic in_t mk(logic [2:0] c, logic w, logic [31:0] a, logic [16:0] l,
                             logic [10:0] s, logic [31:0] h);
    in_t it;
    it.cmd = c;
    it.all_lines = w;
    it.address = a;
    it.length = l;
    it.line_step = s;
    it.content_hash = h;
    return it;
  endfunction

  function automatic void add_item(in_t it);
    row_t r;
    r.is_cfg = 0;
    r.item = it;
    r.typed = 0;
    rows.push_back(r);
  endfunction

  function automatic void add_fixed(in_t it, logic [31:0] la, logic [31:0] vc,
                                    logic [31:0] cc, logic [31:0] dc);
    row_t r;
    r.is_cfg = 0;
    r.item = it;
    r.typed = 1;
    r.want = '{line_address: la, ignored: 1'b1, violation: VIOL_NONE,
               violation_count: vc, cache_op_count: cc, dma_count: dc};
    rows.push_back(r);
  endfunction

  function automatic void add_cfg(cfg_idx_e i, logic [32:0] d);
    row_t r;
    r.is_cfg = 1;
    r.reg_idx = i;
    r.reg_val = d;
    rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_hash();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h811C_9DC5;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] window_addr(int unsigned lines);
    logic [63:0] off;
    off = 64'($urandom_range(0, lines * LINE_BYTES - 1));
    if (size != 0 && off >= size) off = off % size;
    return 32'(base + off);
  endfunction

  // one random stimulus phase: mostly well-formed accesses with some noise
  task automatic random_phase(int n_items, int unsigned lines, bit hold);
    int sent;
    int kind, steps;
    bit held;
    logic [31:0] a;
    logic [16:0] l;
    logic [2:0] c;
    sent = 0;
    held = 0;
    while (sent < n_items) begin
      if (sent % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (hold && !held && sent >= n_items / 2) begin
        long_hold = 1;
        held = 1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send(mk(3'($urandom), 1'($urandom), $urandom, 17'($urandom),
                11'($urandom), $urandom));
        sent++;
      end else if (kind <= 3) begin
        c = 3'($urandom_range(CMD_CLEAN, CMD_FLUSH));
        send(mk(c, size <= 64'h4_0000 && $urandom_range(0, 15) == 0,
                window_addr(lines), 17'($urandom), 11'($urandom), pick_hash()));
        sent++;
      end else begin
        c = $urandom_range(0, 1) ? CMD_DMA_WR : CMD_DMA_RD;
        a = ($urandom_range(0, 2) == 0) ? last_end[31:0] : window_addr(lines);
        l = ($urandom_range(0, 15) == 0) ? 17'($urandom) : 17'($urandom_range(0, 160));
        last_end = 64'(a) + l;
        steps = (((a % LINE_BYTES) + l + LINE_BYTES - 1) / LINE_BYTES);
        if (steps == 0) steps = 1;
        if (steps > 6) steps = 6;
        if ($urandom_range(0, 3) == 0) steps++;
        for (int s = 0; s < steps; s++) begin
          send(mk(c, 1'($urandom), a, l, 11'(s), pick_hash()));
          sent++;
        end
      end
    end
  endtask

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    en = 0; base = '0; size = '0;
    burst_next = 0; continues = 0;
    viol_tot = '0; cop_tot = '0; dma_tot = '0;
    errors = 0; quiet = 0; long_hold = 0; last_end = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      line_st[i] = ST_UNKNOWN;
      line_enr[i] = 0;
      line_sig[i] = '0;
    end
    for (int i = 0; i < BURST_SLOTS; i++) burst_end[i] = '0;

    // disabled: everything ignored, nothing counted
    add_fixed(mk(CMD_DMA_WR, 0, 32'h1000_0040, 17'd32, 0, 0), 32'h1000_0040, 0, 0, 0);
    add_fixed(mk(CMD_CLEAN, 0, 32'h1234_5677, 0, 0, 32'h1), 32'h1234_5660, 0, 0, 0);
    add_cfg(CFG_ENABLE, 33'd1);
    add_cfg(CFG_RAM_BASE, 33'h1000_0000);
    add_cfg(CFG_RAM_SIZE, 33'h1_0000);
    add_fixed(mk(3'd7, 1, 32'h1000_0005, 0, 0, 0), 32'h1000_0000, 0, 0, 0);
    add_item(mk(CMD_INVAL, 0, 32'h1000_0000, 0, 0, 0));
    add_item(mk(CMD_INVAL, 0, 32'h1000_0020, 0, 0, 0));
    add_item(mk(CMD_DMA_WR, 0, 32'h1000_0000, 17'd64, 0, 0));
    add_item(mk(CMD_DMA_WR, 0, 32'h1000_0000, 17'd64, 1, 0));
    add_item(mk(CMD_DMA_WR, 0, 32'h1000_0040, 17'd32, 0, 0));
    add_item(mk(CMD_CLEAN, 0, 32'h1000_0080, 0, 0, 32'hDEAD_BEEF));
    add_item(mk(CMD_DMA_RD, 0, 32'h1000_0080, 17'd32, 0, 32'h1234_5678));
    add_item(mk(CMD_DMA_WR, 0, 32'h1000_0080, 17'd32, 0, 0));
    add_item(mk(CMD_DMA_WR, 0, 32'h1000_0080, 17'd32, 0, 0));
    add_item(mk(CMD_DMA_RD, 0, 32'h1000_0085, 17'd0, 0, 0));
    add_item(mk(CMD_DMA_RD, 0, 32'h1000_0000, 17'd32, 11'd5, 0));
    add_item(mk(CMD_DMA_WR, 0, 32'h1000_0000, 17'h1_0000, 11'd2047, 32'hFFFF_FFFF));
    add_item(mk(CMD_DMA_RD, 0, 32'hFFFF_FFFF, 17'h1_FFFF, 0, 0));
    add_item(mk(CMD_FLUSH, 0, 32'h1000_FFE0, 0, 0, 0));
    add_item(mk(CMD_CLEAN, 0, 32'h0FFF_FFE0, 0, 0, 0));
    add_item(mk(CMD_CLEAN, 1, 32'hFFFF_FFFF, 0, 0, 0));
    add_item(mk(CMD_INVAL, 1, 0, 0, 0, 0));
    add_cfg(CFG_RAM_BASE, 33'h0);
    add_cfg(CFG_RAM_SIZE, 33'h1_0000_0000);
    add_item(mk(CMD_DMA_WR, 0, 32'h0, 17'd32, 0, 0));
    add_item(mk(CMD_FLUSH, 1, 0, 0, 0, 0));
    add_item(mk(CMD_CLEAN, 0, 32'h0020_0000, 0, 0, 0));
    add_cfg(CFG_RAM_SIZE, 33'h0);
    add_item(mk(CMD_CLEAN, 1, 32'h40, 0, 0, 0));
    add_cfg(CFG_RAM_BASE, 33'hFFFF_FFFF);
    add_cfg(CFG_RAM_SIZE, 33'h1);
    add_item(mk(CMD_DMA_RD, 0, 32'hFFFF_FFFF, 17'd1, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        cfg_write(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    // random phases over several RAM windows
    settle(); cfg_write(CFG_RAM_BASE, 33'h1000_0000);
    cfg_write(CFG_RAM_SIZE, 33'h1_0000);
    random_phase(200, 48, 1);
    settle(); cfg_write(CFG_RAM_BASE, 33'h0);
    cfg_write(CFG_RAM_SIZE, 33'h8000);
    last_end = '0;
    random_phase(170, 32, 0);
    settle(); cfg_write(CFG_RAM_BASE, 33'h8000_0010);
    cfg_write(CFG_RAM_SIZE, 33'h50);
    random_phase(120, 4, 0);
    settle(); cfg_write(CFG_ENABLE, 33'd0);
    random_phase(40, 8, 0);
    settle(); cfg_write(CFG_ENABLE, 33'd1);
    cfg_write(CFG_RAM_BASE, 33'hFFFF_0000);
    cfg_write(CFG_RAM_SIZE, 33'h1_0000_0000);
    random_phase(150, 64, 0);
    settle(); cfg_write(CFG_RAM_BASE, 33'h2000_0000);
    cfg_write(CFG_RAM_SIZE, 33'h2_0000);
    random_phase(150, 40, 0);

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== dma_coherency_line_checker.f =====
+incdir+sv
sv/dcl_pkg.sv
sv/dcl_table.sv
sv/dcl_burst.sv
sv/dma_coherency_line_checker.sv
tb/testbench.sv
